### hw/rtl/pnf_pkg.sv
// Shared widths, reset values, register codes and types for the noise floor averager.
package pnf_pkg;

  localparam int BinsDef = 512;
  localparam int BinW    = 9;
  localparam int PwrW    = 32;
  localparam int SumW    = 48;
  localparam int CntW    = 16;
  localparam int EstW    = 32;
  localparam int AddrW   = 3;
  localparam int DataW   = 32;

  localparam logic [EstW-1:0] NoiseReset = 32'd27488;
  localparam logic [CntW-1:0] SlotsReset = 16'd16;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SLOTS  = 1'b0,
    REG_RSTOCC = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  // one bin's state as held in the bin memory
  typedef struct packed {
    logic [EstW-1:0] noise;
    logic [CntW-1:0] cnt;
    logic [SumW-1:0] sum;
  } entry_t;

  localparam int EntryW = EstW + CntW + SumW;

  // handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/pnf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pnf_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module pnf_div
  import pnf_pkg::*;
#(
  parameter int DivW = SumW,
  parameter int VsrW = CntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_ctrl_t       ctrl_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [VsrW-1:0] divisor_i,
  output div_stat_t       stat_o,
  output logic [DivW-1:0] quotient_o
);

  localparam int StepW = $clog2(DivW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [VsrW-1:0]  rem_q, rem_d;
  logic [VsrW-1:0]  dvs_q, dvs_d;
  logic [DivW-1:0]  quo_q, quo_d;
  logic [VsrW:0]    trial;
  logic             fits;

  // dividend shifts out at the top while quotient bits shift in at the bottom
  assign trial = {rem_q, quo_q[DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      step_d = StepW'(DivW);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? VsrW'(trial - {1'b0, dvs_q}) : VsrW'(trial);
      quo_d  = {quo_q[DivW-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

### hw/rtl/per_bin_gated_noise_floor_average.sv
// Top level: per-bin gated block-average noise floor estimator.
//
//  channel   dir  handshake                    content
//  s_axis    in   tvalid/tready                tdata: bin_index, power_sample; tuser: occupied
//  m_axis    out  tvalid/tready                tdata: result_bin, noise_estimate; tuser: updated
//  apb       in   psel/penable/pwrite, pready  0x0 slots_per_average, 0x4 reset_on_occupied
//
// One word at a time: accept, memory read, modify/write, output register load. A word
// that completes an average also waits on the bit-serial divider (48 quotient bits,
// then the done flag) before the bin entry is written back and the result moves on.
// A result held in the output register stalls the next word's load. After reset a
// clearing pass writes every bin entry, one per cycle, with s_axis_tready low. The
// output register lets the next word enter while a result waits.
module per_bin_gated_noise_floor_average
  import pnf_pkg::*;
#(
  parameter int BINS = BinsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // slave stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [47:0]      s_axis_tdata,   // [8:0] bin_index, [40:9] power_sample, zero pad
  input  logic             s_axis_tuser,   // [0] occupied
  // master stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [8:0] result_bin, [40:9] noise_estimate, zero pad
  output logic             m_axis_tuser,   // [0] estimate_updated
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int IdxW = (BINS > 1) ? $clog2(BINS) : 1;

  state_e          state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;

  logic [BinW-1:0] bin_q;
  logic [PwrW-1:0] pwr_q;
  logic            occ_q;
  logic [EstW-1:0] res_est_q, res_est_d;
  logic            res_upd_q, res_upd_d;

  logic [CntW-1:0] slots_q;
  logic            rstocc_q;

  logic            m_valid_q;
  logic [BinW-1:0] m_bin_q;
  logic [EstW-1:0] m_est_q;
  logic            m_upd_q;

  logic            in_acc;
  logic            out_load;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  entry_t          ram_rdata;
  logic [EntryW-1:0] ram_rdata_raw;

  div_ctrl_t       div_ctrl;
  div_stat_t       div_stat;
  logic [SumW-1:0] div_quo;
  logic [EstW-1:0] quo_sat;

  logic            in_range;
  logic [CntW-1:0] slots_eff;
  logic [CntW:0]   cnt_inc;
  logic [SumW-1:0] sum_new;
  logic            complete;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= SlotsReset;
      rstocc_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SLOTS:  slots_q  <= pwdata[CntW-1:0];
        REG_RSTOCC: rstocc_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SLOTS:  prdata = DataW'(slots_q);
      REG_RSTOCC: prdata = DataW'(rstocc_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- bin memory and divider ----------------
  assign in_acc = s_axis_tvalid && s_axis_tready;

  pnf_ram #(
    .Width (EntryW),
    .Depth (BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (IdxW'(s_axis_tdata[BinW-1:0])),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  pnf_div #(
    .DivW (SumW),
    .VsrW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum_new),
    .divisor_i  (slots_eff),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign quo_sat = (div_quo[SumW-1:EstW] != '0) ? '1 : div_quo[EstW-1:0];

  // ---------------- per-word arithmetic ----------------
  assign in_range  = 32'(bin_q) < BINS;
  assign slots_eff = (slots_q == '0) ? CntW'(1) : slots_q;
  assign cnt_inc   = {1'b0, ram_rdata.cnt} + 1'b1;
  assign sum_new   = SumW'(ram_rdata.sum + SumW'(pwr_q));
  assign complete  = cnt_inc >= {1'b0, slots_eff};

  // ---------------- sequencer ----------------
  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    res_est_d      = res_est_q;
    res_upd_d      = res_upd_q;
    ram_we         = 1'b0;
    ram_waddr      = IdxW'(bin_q);
    ram_wdata      = ram_rdata;
    div_ctrl.start = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we          = 1'b1;
        ram_waddr       = clr_q;
        ram_wdata.noise = NoiseReset;
        ram_wdata.cnt   = '0;
        ram_wdata.sum   = '0;
        clr_d           = clr_q + 1'b1;
        if (clr_q == IdxW'(BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        res_upd_d = 1'b0;
        res_est_d = ram_rdata.noise;
        state_d   = ST_OUT;
        if (!in_range) begin
          res_est_d = '0;
        end else if (!occ_q) begin
          if (complete) begin
            div_ctrl.start = 1'b1;
            state_d        = ST_DIV;
          end else begin
            ram_we        = 1'b1;
            ram_wdata.cnt = cnt_inc[CntW-1:0];
            ram_wdata.sum = sum_new;
          end
        end else if (rstocc_q) begin
          ram_we        = 1'b1;
          ram_wdata.cnt = '0;
          ram_wdata.sum = '0;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          ram_we          = 1'b1;
          ram_wdata.noise = quo_sat;
          ram_wdata.cnt   = '0;
          ram_wdata.sum   = '0;
          res_est_d       = quo_sat;
          res_upd_d       = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bin_q <= s_axis_tdata[BinW-1:0];
      pwr_q <= s_axis_tdata[BinW +: PwrW];
      occ_q <= s_axis_tuser;
    end
    res_est_q <= res_est_d;
    res_upd_q <= res_upd_d;
    if (out_load) begin
      m_bin_q <= bin_q;
      m_est_q <= res_est_q;
      m_upd_q <= res_upd_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, m_est_q, m_bin_q};
  assign m_axis_tuser  = m_upd_q;

endmodule
